[hw/rtl/kpc_pkg.sv]
// ----------------------------------------------------------------------------
// kpc_pkg: keypad press classifier shared definitions
// Event codes, key indexes, register indexes, the configuration record and
// the key-pair lookup used by every lane.
// ----------------------------------------------------------------------------
package kpc_pkg;

   localparam int NUM_KEYS = 4;

   typedef logic [1:0]          key_idx_type;
   typedef logic [NUM_KEYS-1:0] key_vec_type;
   typedef logic [3:0]          ev_code_type;
   typedef logic [2:0]          csr_idx_type;
   typedef logic [15:0]         ms_type;

   // key positions
   localparam key_idx_type K_MODE = 2'd0;
   localparam key_idx_type K_SET  = 2'd1;
   localparam key_idx_type K_UP   = 2'd2;
   localparam key_idx_type K_DOWN = 2'd3;

   // event codes
   localparam ev_code_type EV_NONE      = 4'd0;
   localparam ev_code_type EV_INVALID   = 4'd1;
   localparam ev_code_type EV_SHORT     = 4'd2;
   localparam ev_code_type EV_LONG      = 4'd3;
   localparam ev_code_type EV_STUCK     = 4'd4;
   localparam ev_code_type EV_MODE_UP   = 4'd5;
   localparam ev_code_type EV_MODE_SET  = 4'd6;
   localparam ev_code_type EV_MODE_DOWN = 4'd7;
   localparam ev_code_type EV_SET_UP    = 4'd8;
   localparam ev_code_type EV_UP_DOWN   = 4'd9;

   // configuration register indexes
   localparam csr_idx_type REG_DEBOUNCE  = 3'd0;
   localparam csr_idx_type REG_SHORT_MIN = 3'd1;
   localparam csr_idx_type REG_SHORT_MAX = 3'd2;
   localparam csr_idx_type REG_LONG_MIN  = 3'd3;
   localparam csr_idx_type REG_LONG_MAX  = 3'd4;
   localparam csr_idx_type REG_FAULT     = 3'd5;
   localparam csr_idx_type REG_PRESSED   = 3'd6;

   // reset values
   localparam ms_type RST_DEBOUNCE  = 16'd50;
   localparam ms_type RST_SHORT_MIN = 16'd100;
   localparam ms_type RST_SHORT_MAX = 16'd2000;
   localparam ms_type RST_LONG_MIN  = 16'd3000;
   localparam ms_type RST_LONG_MAX  = 16'd5000;
   localparam ms_type RST_FAULT     = 16'd10000;

   typedef struct packed {
      ms_type debounce_ms;
      ms_type short_min_ms;
      ms_type short_max_ms;
      ms_type long_min_ms;
      ms_type long_max_ms;
      ms_type fault_ms;
      logic   pressed_level;
   } cfg_type;

   // combination code for a key pair; none for unsupported pairs
   function automatic ev_code_type pair_code(key_idx_type a, key_idx_type b);
      ev_code_type code;
      code = EV_NONE;
      if ((a == K_MODE && b == K_SET) || (a == K_SET && b == K_MODE)) begin
         code = EV_MODE_SET;
      end else if ((a == K_MODE && b == K_UP) || (a == K_UP && b == K_MODE)) begin
         code = EV_MODE_UP;
      end else if ((a == K_MODE && b == K_DOWN) || (a == K_DOWN && b == K_MODE)) begin
         code = EV_MODE_DOWN;
      end else if ((a == K_SET && b == K_UP) || (a == K_UP && b == K_SET)) begin
         code = EV_SET_UP;
      end else if ((a == K_UP && b == K_DOWN) || (a == K_DOWN && b == K_UP)) begin
         code = EV_UP_DOWN;
      end
      return code;
   endfunction

endpackage

[hw/rtl/kpc_if.sv]
// ----------------------------------------------------------------------------
// kpc_if: keypad press classifier channel interfaces
// Poll channel, event channel and register write channel, valid/ready each.
// ----------------------------------------------------------------------------
interface kpc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] time_now;
   logic        key_mode;
   logic        key_set;
   logic        key_up;
   logic        key_down;
   logic        restart_stamps;

   modport source (output valid, time_now, key_mode, key_set, key_up, key_down,
                   restart_stamps, input ready);
   modport sink   (input valid, time_now, key_mode, key_set, key_up, key_down,
                   restart_stamps, output ready);
endinterface

interface kpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] mode_event;
   logic [3:0] set_event;
   logic [3:0] up_event;
   logic [3:0] down_event;

   modport source (output valid, mode_event, set_event, up_event, down_event,
                   input ready);
   modport sink   (input valid, mode_event, set_event, up_event, down_event,
                   output ready);
endinterface

interface kpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/kpc_lane.sv]
// ----------------------------------------------------------------------------
// kpc_lane: per-key press classifier
// Holds one key's timestamp, held latch and combination flag, and classifies
// the key for the poll on its inputs; state advances when the item is taken.
// ----------------------------------------------------------------------------
module kpc_lane #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  kpc_pkg::key_idx_type    lane_id,
   input  logic [TIME_WIDTH-1:0]   now,
   input  kpc_pkg::key_vec_type    pressed,
   input  logic                    restart,
   input  kpc_pkg::cfg_type        cfg,
   output kpc_pkg::ev_code_type    ev
);
   import kpc_pkg::*;

   logic [TIME_WIDTH-1:0] stamp_ff, stamp_in;
   logic                  latch_ff, latch_in;
   logic                  combo_ff, combo_in;

   logic [TIME_WIDTH-1:0] elapsed;
   logic [TIME_WIDTH-1:0] debounce_w, short_min_w, short_max_w;
   logic [TIME_WIDTH-1:0] long_min_w, long_max_w, fault_w;
   logic [2:0]            others;
   key_idx_type           partner;
   logic                  own;
   logic                  latch_solo;
   ev_code_type           long_code;

   assign debounce_w  = TIME_WIDTH'(cfg.debounce_ms);
   assign short_min_w = TIME_WIDTH'(cfg.short_min_ms);
   assign short_max_w = TIME_WIDTH'(cfg.short_max_ms);
   assign long_min_w  = TIME_WIDTH'(cfg.long_min_ms);
   assign long_max_w  = TIME_WIDTH'(cfg.long_max_ms);
   assign fault_w     = TIME_WIDTH'(cfg.fault_ms);

   // other keys down, and which one if a single partner
   always_comb begin
      others  = 3'd0;
      partner = K_MODE;
      for (int j = 0; j < NUM_KEYS; j++) begin
         if (key_idx_type'(j) != lane_id && pressed[j]) begin
            others  = others + 3'd1;
            partner = key_idx_type'(j);
         end
      end
   end

   assign own = pressed[lane_id];

   // timestamp follows time while unlatched; restart reloads it first
   always_comb begin
      stamp_in = stamp_ff;
      if (restart || !latch_ff) begin
         stamp_in = now;
      end
   end

   assign elapsed    = now - stamp_in;
   assign latch_solo = latch_ff || (own && others == 3'd0 && elapsed < short_max_w);

   always_comb begin
      long_code = EV_NONE;
      if (others == 3'd0) begin
         long_code = EV_LONG;
      end else if (others == 3'd1) begin
         long_code = pair_code(lane_id, partner);
      end
   end

   // classification, first matching rule wins
   always_comb begin
      ev       = EV_NONE;
      latch_in = latch_solo;
      combo_in = combo_ff;
      priority if (own && !combo_ff && elapsed > long_min_w && elapsed < long_max_w
                   && long_code != EV_NONE) begin
         ev       = long_code;
         latch_in = 1'b1;
         combo_in = 1'b1;
      end else if (latch_solo && !own) begin
         latch_in = 1'b0;
         combo_in = 1'b0;
         if (elapsed <= debounce_w) begin
            ev = EV_INVALID;
         end else if (elapsed > short_min_w && elapsed < short_max_w) begin
            ev = EV_SHORT;
         end else if (elapsed > fault_w) begin
            ev = EV_STUCK;
         end
      end else if (own && elapsed >= long_max_w) begin
         ev       = EV_STUCK;
         latch_in = 1'b1;
      end else begin
         ev = EV_NONE;
      end
   end

   // key state
   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
         latch_ff <= 1'b0;
         combo_ff <= 1'b0;
      end else if (accept) begin
         stamp_ff <= stamp_in;
         latch_ff <= latch_in;
         combo_ff <= combo_in;
      end
   end

`ifndef SYNTHESIS
   // a reported combination always keeps the key latched
   assert property (@(posedge clock) disable iff (reset) combo_ff |-> latch_ff)
      else $error("kpc_lane: combination flag set without latch");
   // a latched key keeps its stamp unless restarted
   assert property (@(posedge clock) disable iff (reset)
      (accept && latch_ff && !restart) |=> $stable(stamp_ff))
      else $error("kpc_lane: latched stamp moved");
   // release of a latched key clears latch and flag
   assert property (@(posedge clock) disable iff (reset)
      (accept && latch_ff && !own) |=> (!latch_ff && !combo_ff))
      else $error("kpc_lane: release left key latched");
`endif

endmodule

[hw/rtl/kpc_merge.sv]
// ----------------------------------------------------------------------------
// kpc_merge: event merge and output register
// Gathers the four lane events into one result item and holds it until the
// consumer takes it; takes a new item whenever the register frees this cycle.
// ----------------------------------------------------------------------------
module kpc_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  kpc_pkg::ev_code_type    ev_mode,
   input  kpc_pkg::ev_code_type    ev_set,
   input  kpc_pkg::ev_code_type    ev_up,
   input  kpc_pkg::ev_code_type    ev_down,
   kpc_rsp_if.source               rsp
);
   import kpc_pkg::*;

   logic        valid_ff, valid_in;
   ev_code_type mode_ff, set_ff, up_ff, down_ff;
   logic        take;

   assign in_ready = !valid_ff || rsp.ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (take) begin
         mode_ff <= ev_mode;
         set_ff  <= ev_set;
         up_ff   <= ev_up;
         down_ff <= ev_down;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.mode_event = mode_ff;
   assign rsp.set_event  = set_ff;
   assign rsp.up_event   = up_ff;
   assign rsp.down_event = down_ff;

`ifndef SYNTHESIS
   // every taken item shows up at the output next cycle
   assert property (@(posedge clock) disable iff (reset) take |=> valid_ff)
      else $error("kpc_merge: taken item not presented");
   // an empty output register never blocks input
   assert property (@(posedge clock) disable iff (reset) !valid_ff |-> in_ready)
      else $error("kpc_merge: stalled while empty");
   // codes stay in the defined range
   assert property (@(posedge clock) disable iff (reset) valid_ff |->
      (mode_ff <= EV_UP_DOWN && set_ff <= EV_UP_DOWN &&
       up_ff <= EV_UP_DOWN && down_ff <= EV_UP_DOWN))
      else $error("kpc_merge: event code out of range");
`endif

endmodule

[hw/rtl/keypad_press_classifier_core.sv]
// ----------------------------------------------------------------------------
// keypad_press_classifier_core: four-key short/long/combination classifier
//
//   channel  dir  handshake      carries
//   req_chan in   valid/ready    time_now, four key levels, restart_stamps
//   rsp_chan out  valid/ready    mode/set/up/down event codes
//   csr_chan in   valid/ready    register index, 16-bit write data
//
// One poll per cycle; a poll's result appears the cycle after it is taken.
// Four key lanes classify in parallel from registered key state and the
// current poll; one output register holds the merged result.
// Polls are taken while the output register is empty or being drained.
// Synchronous reset restores register defaults and clears key state.
// Register writes are always accepted.
// ----------------------------------------------------------------------------
module keypad_press_classifier_core #(
   parameter int TIME_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   kpc_req_if.sink    req_chan,
   kpc_rsp_if.source  rsp_chan,
   kpc_csr_if.sink    csr_chan
);
   import kpc_pkg::*;

   cfg_type               cfg_ff;
   logic [TIME_WIDTH-1:0] now;
   key_vec_type           levels;
   key_vec_type           pressed;
   logic                  accept;
   logic                  in_ready;
   ev_code_type           ev [NUM_KEYS];

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= RST_DEBOUNCE;
         cfg_ff.short_min_ms  <= RST_SHORT_MIN;
         cfg_ff.short_max_ms  <= RST_SHORT_MAX;
         cfg_ff.long_min_ms   <= RST_LONG_MIN;
         cfg_ff.long_max_ms   <= RST_LONG_MAX;
         cfg_ff.fault_ms      <= RST_FAULT;
         cfg_ff.pressed_level <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_DEBOUNCE:  cfg_ff.debounce_ms   <= csr_chan.data;
            REG_SHORT_MIN: cfg_ff.short_min_ms  <= csr_chan.data;
            REG_SHORT_MAX: cfg_ff.short_max_ms  <= csr_chan.data;
            REG_LONG_MIN:  cfg_ff.long_min_ms   <= csr_chan.data;
            REG_LONG_MAX:  cfg_ff.long_max_ms   <= csr_chan.data;
            REG_FAULT:     cfg_ff.fault_ms      <= csr_chan.data;
            REG_PRESSED:   cfg_ff.pressed_level <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   // poll decode
   assign now    = TIME_WIDTH'(req_chan.time_now);
   assign levels = {req_chan.key_down, req_chan.key_up, req_chan.key_set,
                    req_chan.key_mode};

   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         pressed[k] = (levels[k] == cfg_ff.pressed_level);
      end
   end

   assign req_chan.ready = in_ready;
   assign accept         = req_chan.valid && in_ready;

   // key lanes
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      kpc_lane #(
         .TIME_WIDTH (TIME_WIDTH)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .accept  (accept),
         .lane_id (key_idx_type'(k)),
         .now     (now),
         .pressed (pressed),
         .restart (req_chan.restart_stamps),
         .cfg     (cfg_ff),
         .ev      (ev[k])
      );
   end

   // merge and output register
   kpc_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (in_ready),
      .ev_mode  (ev[K_MODE]),
      .ev_set   (ev[K_SET]),
      .ev_up    (ev[K_UP]),
      .ev_down  (ev[K_DOWN]),
      .rsp      (rsp_chan)
   );

endmodule
